>>> rtl/bitp_pkg.sv
// shared types, codes and helper functions of the boolean infix to postfix converter
`default_nettype none
package bitp_pkg;

  // characters of the expression language
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OR    = 8'h2B;
  localparam logic [7:0] CH_AND   = 8'h2E;
  localparam logic [7:0] CH_NOT   = 8'h7E;

  // operand ranges, bounds exclusive
  localparam logic [7:0] DIGIT_LO = 8'd47;
  localparam logic [7:0] DIGIT_HI = 8'd50;
  localparam logic [7:0] LOWER_LO = 8'd96;
  localparam logic [7:0] LOWER_HI = 8'd123;
  localparam logic [7:0] UPPER_LO = 8'd64;
  localparam logic [7:0] UPPER_HI = 8'd91;

  localparam logic [7:0] MAX_LEN_RESET = 8'd50;
  localparam logic [7:0] COUNT_SAT     = 8'hFF;

  // stack entry codes
  localparam logic [1:0] OP_OPEN = 2'd0;
  localparam logic [1:0] OP_OR   = 2'd1;
  localparam logic [1:0] OP_AND  = 2'd2;
  localparam logic [1:0] OP_NOT  = 2'd3;

  // class of the previous token
  localparam logic [2:0] PC_NONE    = 3'd0;
  localparam logic [2:0] PC_OPERAND = 3'd1;
  localparam logic [2:0] PC_CLOSE   = 3'd2;
  localparam logic [2:0] PC_OPEN    = 3'd3;
  localparam logic [2:0] PC_NOT     = 3'd4;
  localparam logic [2:0] PC_BINARY  = 3'd5;

  // kind of the current character
  localparam logic [2:0] K_SPACE = 3'd0;
  localparam logic [2:0] K_OPEN  = 3'd1;
  localparam logic [2:0] K_CLOSE = 3'd2;
  localparam logic [2:0] K_NOT   = 3'd3;
  localparam logic [2:0] K_OR    = 3'd4;
  localparam logic [2:0] K_AND   = 3'd5;
  localparam logic [2:0] K_OPND  = 3'd6;
  localparam logic [2:0] K_BAD   = 3'd7;

  // status carried by the end word
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR    = 3'd1;
  localparam logic [2:0] ST_BAD_ORDER   = 3'd2;
  localparam logic [2:0] ST_STRAY_CLOSE = 3'd3;
  localparam logic [2:0] ST_BAD_END     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG    = 3'd5;
  localparam logic [2:0] ST_OVERFLOW    = 3'd6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       take;
    logic       set_err;
    logic [2:0] err_val;
    logic       push;
    logic [1:0] push_code;
    logic       pop;
    logic       open_inc;
    logic       open_dec;
    logic       set_prev;
    logic [2:0] prev_val;
    logic       emit_char;
    logic       emit_op;
    logic       emit_end;
    logic       clear;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic       in_valid;
    logic       err_nz;
    logic       too_long;
    logic [2:0] kind;
    logic       value_end;
    logic       open_zero;
    logic       sp_zero;
    logic       sp_full;
    logic       top_open;
    logic       prec_ge;
    logic       last;
    logic       slot_free;
  } sts_t;

  function automatic logic [2:0] char_kind(input logic [7:0] c);
    logic [2:0] k;
    if (c == CH_SPACE) k = K_SPACE;
    else if (c == CH_OPEN) k = K_OPEN;
    else if (c == CH_CLOSE) k = K_CLOSE;
    else if (c == CH_NOT) k = K_NOT;
    else if (c == CH_OR) k = K_OR;
    else if (c == CH_AND) k = K_AND;
    else if ((c > DIGIT_LO && c < DIGIT_HI) || (c > LOWER_LO && c < LOWER_HI) ||
             (c > UPPER_LO && c < UPPER_HI)) k = K_OPND;
    else k = K_BAD;
    return k;
  endfunction

  function automatic logic [7:0] op_char(input logic [1:0] code);
    logic [7:0] ch;
    case (code)
      OP_OPEN: ch = CH_OPEN;
      OP_OR:   ch = CH_OR;
      OP_AND:  ch = CH_AND;
      default: ch = CH_NOT;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] op_prec(input logic [1:0] code);
    logic [2:0] p;
    case (code)
      OP_OPEN: p = 3'd0;
      OP_OR:   p = 3'd1;
      OP_AND:  p = 3'd2;
      default: p = 3'd4;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bitp_char_if.sv
// input channel carrying one character of the infix expression
`default_nettype none
interface bitp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

>>> rtl/bitp_sym_if.sv
// output channel carrying postfix symbols and the end word
`default_nettype none
interface bitp_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic       end_of_expr;
  logic [2:0] status;
  modport source (output valid, output symbol, output symbol_valid, output end_of_expr,
                  output status, input ready);
  modport sink   (input valid, input symbol, input symbol_valid, input end_of_expr,
                  input status, output ready);
endinterface
`default_nettype wire

>>> rtl/bitp_cfg_if.sv
// configuration write channel for the maximum length register
`default_nettype none
interface bitp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bitp_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bitp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/bitp_ctrl.sv
// controller state machine sequencing decode, stack pops, flush and end word
`default_nettype none
module bitp_ctrl
  import bitp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CL_RD  = 4'd2;
  localparam logic [3:0] S_CL_CHK = 4'd3;
  localparam logic [3:0] S_BN_RD  = 4'd4;
  localparam logic [3:0] S_BN_CHK = 4'd5;
  localparam logic [3:0] S_LAST   = 4'd6;
  localparam logic [3:0] S_FL_RD  = 4'd7;
  localparam logic [3:0] S_FL_CHK = 4'd8;
  localparam logic [3:0] S_END    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] after_char;
  logic [1:0] bin_code;

  assign after_char = sts.last ? S_LAST : S_IDLE;
  assign bin_code   = (sts.kind == K_OR) ? OP_OR : OP_AND;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = after_char;
        if (sts.err_nz) begin
          state_next = after_char;
        end else if (sts.too_long) begin
          cmd.set_err = 1'b1;
          cmd.err_val = ST_TOO_LONG;
        end else begin
          case (sts.kind)
            K_SPACE: state_next = after_char;
            K_OPEN, K_NOT: begin
              if (sts.value_end) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_BAD_ORDER;
              end else if (sts.sp_full) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_OVERFLOW;
              end else begin
                cmd.push     = 1'b1;
                cmd.set_prev = 1'b1;
                if (sts.kind == K_OPEN) begin
                  cmd.push_code = OP_OPEN;
                  cmd.open_inc  = 1'b1;
                  cmd.prev_val  = PC_OPEN;
                end else begin
                  cmd.push_code = OP_NOT;
                  cmd.prev_val  = PC_NOT;
                end
              end
            end
            K_CLOSE: begin
              if (sts.open_zero) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_STRAY_CLOSE;
              end else if (!sts.value_end) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_BAD_ORDER;
              end else begin
                state_next = S_CL_RD;
              end
            end
            K_OR, K_AND: begin
              if (!sts.value_end) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_BAD_ORDER;
              end else begin
                state_next = S_BN_RD;
              end
            end
            K_OPND: begin
              if (sts.value_end) begin
                cmd.set_err = 1'b1;
                cmd.err_val = ST_BAD_ORDER;
              end else if (sts.slot_free) begin
                cmd.emit_char = 1'b1;
                cmd.set_prev  = 1'b1;
                cmd.prev_val  = PC_OPERAND;
              end else begin
                state_next = S_DECODE;
              end
            end
            default: begin
              cmd.set_err = 1'b1;
              cmd.err_val = ST_BAD_CHAR;
            end
          endcase
        end
      end
      // pop down to the matching open parenthesis
      S_CL_RD: begin
        if (sts.sp_zero) begin
          cmd.open_dec = 1'b1;
          cmd.set_prev = 1'b1;
          cmd.prev_val = PC_CLOSE;
          state_next   = after_char;
        end else begin
          state_next = S_CL_CHK;
        end
      end
      S_CL_CHK: begin
        if (sts.top_open) begin
          cmd.pop      = 1'b1;
          cmd.open_dec = 1'b1;
          cmd.set_prev = 1'b1;
          cmd.prev_val = PC_CLOSE;
          state_next   = after_char;
        end else if (sts.slot_free) begin
          cmd.emit_op = 1'b1;
          cmd.pop     = 1'b1;
          state_next  = S_CL_RD;
        end
      end
      // pop operators of equal or higher precedence, then push
      S_BN_RD, S_BN_CHK: begin
        if (state == S_BN_RD && !sts.sp_zero) begin
          state_next = S_BN_CHK;
        end else if (state == S_BN_CHK && sts.prec_ge) begin
          if (sts.slot_free) begin
            cmd.emit_op = 1'b1;
            cmd.pop     = 1'b1;
            state_next  = S_BN_RD;
          end
        end else begin
          state_next = after_char;
          if (sts.sp_full) begin
            cmd.set_err = 1'b1;
            cmd.err_val = ST_OVERFLOW;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_code = bin_code;
            cmd.set_prev  = 1'b1;
            cmd.prev_val  = PC_BINARY;
          end
        end
      end
      // ending checks on the final character
      S_LAST: begin
        if (sts.err_nz) begin
          state_next = S_END;
        end else if (!sts.open_zero || !sts.value_end) begin
          cmd.set_err = 1'b1;
          cmd.err_val = ST_BAD_END;
          state_next  = S_END;
        end else begin
          state_next = S_FL_RD;
        end
      end
      S_FL_RD: begin
        state_next = sts.sp_zero ? S_END : S_FL_CHK;
      end
      S_FL_CHK: begin
        if (sts.slot_free) begin
          cmd.emit_op = 1'b1;
          cmd.pop     = 1'b1;
          state_next  = S_FL_RD;
        end
      end
      S_END: begin
        if (sts.slot_free) begin
          cmd.emit_end = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/bitp_dp.sv
// datapath: character register, expression state, operator stack and output register
`default_nettype none
module bitp_dp
  import bitp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bitp_char_if.sink  char_in,
  bitp_sym_if.source sym_out,
  bitp_cfg_if.sink   cfg,
  input  wire cmd_t  cmd,
  output sts_t       sts
);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  logic [SP_W-1:0] sp;
  logic [7:0]      open_count;
  logic [2:0]      prev_class;
  logic [7:0]      char_count;
  logic [2:0]      err_code;
  logic [7:0]      max_length;
  logic [7:0]      char_reg;
  logic            last_reg;
  logic            out_valid;
  logic [7:0]      out_symbol;
  logic            out_sym_valid;
  logic            out_end;
  logic [2:0]      out_status;
  logic [1:0]      top_code;
  logic [SP_W-1:0] sp_dec;
  logic [2:0]      kind;
  logic [1:0]      bin_code;
  logic            accept;
  logic            emit;

  assign accept   = char_in.valid && cmd.take;
  assign emit     = cmd.emit_char || cmd.emit_op || cmd.emit_end;
  assign sp_dec   = sp - 1'b1;
  assign kind     = char_kind(char_reg);
  assign bin_code = (kind == K_OR) ? OP_OR : OP_AND;

  assign char_in.ready = cmd.take;
  assign cfg.ready     = 1'b1;

  // operator stack, read port always at the top entry
  bitp_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp[AW-1:0]),
    .wdata (cmd.push_code),
    .raddr (sp_dec[AW-1:0]),
    .rdata (top_code)
  );

  // status towards the controller
  always_comb begin
    sts           = '0;
    sts.in_valid  = char_in.valid;
    sts.err_nz    = (err_code != ST_OK);
    sts.too_long  = (char_count > max_length);
    sts.kind      = kind;
    sts.value_end = (prev_class == PC_OPERAND) || (prev_class == PC_CLOSE);
    sts.open_zero = (open_count == 8'd0);
    sts.sp_zero   = (sp == '0);
    sts.sp_full   = (sp == SP_W'(STACK_DEPTH));
    sts.top_open  = (top_code == OP_OPEN);
    sts.prec_ge   = (op_prec(top_code) >= op_prec(bin_code));
    sts.last      = last_reg;
    sts.slot_free = !out_valid || sym_out.ready;
  end

  // maximum length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.data;
    end
  end

  // incoming character
  always_ff @(posedge clk) begin
    if (accept) begin
      char_reg <= char_in.char_code;
      last_reg <= char_in.last_char;
    end
  end

  // expression state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sp         <= '0;
      open_count <= '0;
      prev_class <= PC_NONE;
      char_count <= '0;
      err_code   <= ST_OK;
    end else begin
      if (accept && err_code == ST_OK && char_count != COUNT_SAT) begin
        char_count <= char_count + 8'd1;
      end
      if (cmd.set_err) begin
        err_code <= cmd.err_val;
      end
      if (cmd.push) begin
        sp <= sp + 1'b1;
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.open_inc) begin
        open_count <= open_count + 8'd1;
      end else if (cmd.open_dec) begin
        open_count <= open_count - 8'd1;
      end
      if (cmd.set_prev) begin
        prev_class <= cmd.prev_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (sym_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sym_valid <= !cmd.emit_end;
      out_end       <= cmd.emit_end;
      out_status    <= cmd.emit_end ? err_code : ST_OK;
      if (cmd.emit_char) begin
        out_symbol <= char_reg;
      end else if (cmd.emit_op) begin
        out_symbol <= op_char(top_code);
      end else begin
        out_symbol <= 8'd0;
      end
    end
  end

  assign sym_out.valid        = out_valid;
  assign sym_out.symbol       = out_symbol;
  assign sym_out.symbol_valid = out_sym_valid;
  assign sym_out.end_of_expr  = out_end;
  assign sym_out.status       = out_status;
endmodule
`default_nettype wire

>>> rtl/boolean_infix_to_postfix.sv
// top level of the boolean infix to postfix converter
//
// char_in takes one character per word with last_char marking the end of the
// expression. sym_out gives the postfix symbols in order, then one end word
// with symbol_valid low, end_of_expr high and the status code. cfg writes the
// maximum length register (reset value 50); write it only while the block is
// idle.
// One character is taken at a time. Each one passes the idle state, where it
// is taken, and the decode state; a space, open parenthesis, ~, bad character
// or any character after an error needs no more, and an operand waits there
// for a free output register before it is emitted. Each operator popped from
// the stack takes a stack ram read, then a compare and emit. A close pops down
// to its open parenthesis and drops it; a binary operator pops operators of
// equal or higher precedence, then is pushed. The last character adds the
// ending check, then for a good expression the flush down to the empty stack
// probe, and the end word. Reset clears the expression state and the output
// valid flag; the stack ram is not cleared and needs no clearing pass. While
// sym_out is stalled the pending word holds and the controller waits before
// its next emission.
`default_nettype none
module boolean_infix_to_postfix
  import bitp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  bitp_char_if.sink  char_in,
  bitp_sym_if.source sym_out,
  bitp_cfg_if.sink   cfg
);
  cmd_t cmd;
  sts_t sts;

  // controller
  bitp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // datapath
  bitp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .sym_out (sym_out),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts)
  );

  // no push onto a full stack
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !sts.sp_full)
    else $error("push onto full operator stack");

  // no pop from an empty stack
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !sts.sp_zero)
    else $error("pop from empty operator stack");

  // emission only into a free output slot
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_char || cmd.emit_op || cmd.emit_end) |-> sts.slot_free)
    else $error("emission overwrites pending output word");

  // one character at a time
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready) |=> !char_in.ready)
    else $error("character taken while previous one in progress");
endmodule
`default_nettype wire

>>> bench/testbench.sv
// self-checking testbench for the boolean infix to postfix converter
`timescale 1ns / 100ps
module testbench;
  import bitp_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int IDLE_PCT     = 15;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 20;

  // stack codes are ordered by binding strength, so codes compare like precedences
  localparam logic [7:0] OP_GLYPH [4] = '{CH_OPEN, CH_OR, CH_AND, CH_NOT};
  localparam logic [7:0] FLAW_CHARS [6] = '{CH_OPEN, CH_CLOSE, CH_OR, CH_AND, CH_NOT, CH_SPACE};

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_of_expr;
    logic [2:0] status;
  } sym_word_t;

  logic clk = 1'b0;
  logic rst;

  bitp_char_if char_bus ();
  bitp_sym_if  sym_bus ();
  bitp_cfg_if  cfg_bus ();

  boolean_infix_to_postfix #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .sym_out (sym_bus),
    .cfg     (cfg_bus)
  );

  always #2 clk = ~clk;

  // converter state as the scoreboard sees it
  logic [1:0]  op_stk [STACK_DEPTH];
  int unsigned stk_ptr;
  int unsigned open_cnt;
  int unsigned char_cnt;
  logic [2:0]  prev_cls;
  logic [2:0]  err_code;
  logic [7:0]  max_len;

  sym_word_t   postfix_q [$];
  sym_word_t   want_word;
  logic [7:0]  expr_chars [$];
  int unsigned chars_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cnt = 0;
  bit          steady = 1'b0;

  function automatic void clear_expr();
    stk_ptr  = 0;
    open_cnt = 0;
    char_cnt = 0;
    prev_cls = PC_NONE;
    err_code = ST_OK;
  endfunction

  function automatic void pop_emit();
    stk_ptr--;
    postfix_q.push_back(sym_word_t'{OP_GLYPH[op_stk[stk_ptr]], 1'b1, 1'b0, ST_OK});
  endfunction

  function automatic bit push_op(input logic [1:0] code);
    if (stk_ptr >= STACK_DEPTH) begin
      err_code = ST_OVERFLOW;
      return 1'b0;
    end
    op_stk[stk_ptr] = code;
    stk_ptr++;
    return 1'b1;
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h31) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // one character through the shunting yard
  function automatic void take_char(input logic [7:0] c);
    bit         val_end;
    logic [1:0] code;
    val_end = (prev_cls == PC_OPERAND) || (prev_cls == PC_CLOSE);
    if (char_cnt < 255) char_cnt++;
    if (char_cnt > max_len) begin
      err_code = ST_TOO_LONG;
      return;
    end
    case (c)
      CH_SPACE: begin
      end
      CH_OPEN: begin
        if (val_end) err_code = ST_BAD_ORDER;
        else if (push_op(OP_OPEN)) begin
          open_cnt++;
          prev_cls = PC_OPEN;
        end
      end
      CH_CLOSE: begin
        if (open_cnt == 0) err_code = ST_STRAY_CLOSE;
        else if (!val_end) err_code = ST_BAD_ORDER;
        else begin
          while (stk_ptr > 0 && op_stk[stk_ptr - 1] != OP_OPEN) pop_emit();
          if (stk_ptr > 0) stk_ptr--;
          open_cnt--;
          prev_cls = PC_CLOSE;
        end
      end
      CH_NOT: begin
        if (val_end) err_code = ST_BAD_ORDER;
        else if (push_op(OP_NOT)) prev_cls = PC_NOT;
      end
      CH_OR, CH_AND: begin
        if (!val_end) err_code = ST_BAD_ORDER;
        else begin
          code = (c == CH_OR) ? OP_OR : OP_AND;
          while (stk_ptr > 0 && op_stk[stk_ptr - 1] >= code) pop_emit();
          if (push_op(code)) prev_cls = PC_BINARY;
        end
      end
      default: begin
        if (!is_operand(c)) err_code = ST_BAD_CHAR;
        else if (val_end) err_code = ST_BAD_ORDER;
        else begin
          postfix_q.push_back(sym_word_t'{c, 1'b1, 1'b0, ST_OK});
          prev_cls = PC_OPERAND;
        end
      end
    endcase
  endfunction

  // expected words for one accepted character, end word and flush included
  function automatic void predict_postfix(input logic [7:0] c, input bit last);
    if (err_code == ST_OK) take_char(c);
    if (last) begin
      if (err_code == ST_OK) begin
        if (open_cnt != 0 || !(prev_cls == PC_OPERAND || prev_cls == PC_CLOSE))
          err_code = ST_BAD_END;
        else
          while (stk_ptr > 0) pop_emit();
      end
      postfix_q.push_back(sym_word_t'{8'd0, 1'b0, 1'b1, err_code});
      clear_expr();
    end
  endfunction

  // expression builders
  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0: return 8'h30 + 8'($urandom_range(0, 1));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic void put_tok(input logic [7:0] c);
    if ($urandom_range(0, 99) < 8) expr_chars.push_back(CH_SPACE);
    expr_chars.push_back(c);
  endfunction

  function automatic void build_wellformed(input int tokens, input int nest_max);
    int i;
    int pick;
    int nest;
    bit val_end;
    expr_chars.delete();
    nest = 0;
    val_end = 1'b0;
    for (i = 0; i < tokens; i++) begin
      pick = $urandom_range(0, 9);
      if (!val_end) begin
        if (pick < 2 && nest < nest_max) begin
          put_tok(CH_OPEN);
          nest++;
        end else if (pick < 4) begin
          put_tok(CH_NOT);
        end else begin
          put_tok(rand_operand());
          val_end = 1'b1;
        end
      end else if (pick < 3 && nest > 0) begin
        put_tok(CH_CLOSE);
        nest--;
      end else begin
        put_tok(pick < 6 ? CH_OR : CH_AND);
        val_end = 1'b0;
      end
    end
    if (!val_end) put_tok(rand_operand());
    repeat (nest) put_tok(CH_CLOSE);
  endfunction

  function automatic void build_deep(input int depth);
    int nest;
    expr_chars.delete();
    nest = 0;
    repeat (depth) begin
      if ($urandom_range(0, 1)) begin
        expr_chars.push_back(CH_OPEN);
        nest++;
      end else begin
        expr_chars.push_back(CH_NOT);
      end
    end
    expr_chars.push_back(rand_operand());
    repeat (nest) expr_chars.push_back(CH_CLOSE);
  endfunction

  // one character word, with random hold-off before it outside the steady phase
  task automatic send_char(input logic [7:0] c, input bit last);
    if (!steady)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        char_bus.valid = 1'b0;
        char_bus.char_code = 8'($urandom_range(0, 255));
        @(negedge clk);
      end
    char_bus.valid = 1'b1;
    char_bus.char_code = c;
    char_bus.last_char = last;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    predict_postfix(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    int i;
    for (i = 0; i < expr_chars.size(); i++) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    int i;
    expr_chars.delete();
    for (i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
    send_queued();
  endtask

  // hold the input until every pending word has come out
  task automatic drain_results();
    char_bus.valid = 1'b0;
    while (postfix_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.data = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    max_len = value;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // all operators, precedence, nesting and operand extremes
  task automatic test_operators();
    send_text("0");
    send_text("a.b+~(C+1)");
    send_text("~~Z.(z)");
  endtask

  // bad character, bad order, stray close and bad end statuses, first error wins
  task automatic test_error_codes();
    send_text("a#");
    send_char(8'd0, 1'b1);
    send_char(8'd255, 1'b1);
    send_text("ab");
    send_text(")");
    send_text("(a.)");
    send_text("(a");
    send_text(" ");
    send_text("a+");
  endtask

  // a one character limit, then a spaced out expression under the longest limit
  task automatic test_length_limit();
    write_max_length(8'd1);
    send_text("a");
    send_text("ab");
    write_max_length(8'd255);
    expr_chars.delete();
    expr_chars.push_back(8'h61);
    repeat (20) expr_chars.push_back(CH_SPACE);
    expr_chars.push_back(CH_OR);
    expr_chars.push_back(8'h62);
    send_queued();
  endtask

  // a full stack is fine, one more push overflows
  task automatic test_stack_depth();
    int n;
    for (n = STACK_DEPTH; n <= STACK_DEPTH + 1; n++) begin
      expr_chars.delete();
      repeat (n) expr_chars.push_back(CH_NOT);
      expr_chars.push_back(8'h41);
      send_queued();
    end
  endtask

  task automatic run_random_phase(input logic [7:0] limit, input int unsigned items, input bit deep);
    int unsigned target;
    int pick;
    int pos;
    write_max_length(limit);
    target = chars_sent + items;
    while (chars_sent < target) begin
      pick = $urandom_range(0, 99);
      if (deep && pick < 6) begin
        build_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2));
      end else if (pick < 16) begin
        expr_chars.delete();
        repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_wellformed($urandom_range(1, 14), $urandom_range(0, 4));
        // spoil one character of some expressions
        if (pick < 26) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          if ($urandom_range(0, 1)) expr_chars[pos] = 8'($urandom_range(0, 255));
          else expr_chars[pos] = FLAW_CHARS[$urandom_range(0, 5)];
        end
      end
      send_queued();
      // now and then the sender waits for the output to catch up
      if (pick == 99) drain_results();
    end
  endtask

  task automatic test_random();
    run_random_phase(8'd255, 35, 1'b1);
    run_random_phase(8'($urandom_range(6, 30)), 30, 1'b0);
    steady = 1'b1;
    run_random_phase(8'd60, 35, 1'b0);
    steady = 1'b0;
    drain_results();
    run_random_phase(MAX_LEN_RESET, 30, 1'b0);
  endtask

  // output side stalls at random outside the steady phase
  always @(negedge clk)
    sym_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // compare each output word with the oldest expected one
  always @(posedge clk) begin
    if (!rst && sym_bus.valid && sym_bus.ready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected word: symbol %0d end_of_expr %0b status %0d",
               sym_bus.symbol, sym_bus.end_of_expr, sym_bus.status);
        fail_cnt++;
      end else begin
        want_word = postfix_q.pop_front();
        if (sym_bus.symbol !== want_word.symbol) begin
          $error("symbol: expected %0d, got %0d", want_word.symbol, sym_bus.symbol);
          fail_cnt++;
        end
        if (sym_bus.symbol_valid !== want_word.symbol_valid) begin
          $error("symbol_valid: expected %0b, got %0b", want_word.symbol_valid,
                 sym_bus.symbol_valid);
          fail_cnt++;
        end
        if (sym_bus.end_of_expr !== want_word.end_of_expr) begin
          $error("end_of_expr: expected %0b, got %0b", want_word.end_of_expr,
                 sym_bus.end_of_expr);
          fail_cnt++;
        end
        if (sym_bus.status !== want_word.status) begin
          $error("status: expected %0d, got %0d", want_word.status, sym_bus.status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (char_bus.valid && char_bus.ready) || (sym_bus.valid && sym_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.char_code = 8'd0;
    char_bus.last_char = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = 8'd0;
    clear_expr();
    max_len = MAX_LEN_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_operators();
    test_error_codes();
    test_length_limit();
    test_stack_depth();
    test_random();

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
